@@ design/spring_damper_edge_force_accumulator_assert.svh @@
// Assertion macros used by the force accumulator back end.
`ifndef SPRING_DAMPER_EDGE_FORCE_ACCUMULATOR_ASSERT_SVH
`define SPRING_DAMPER_EDGE_FORCE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SDEFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SDEFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sdefa_pkg.sv @@
// Types and constants of the spring-damper edge force accumulator.
`default_nettype none
package sdefa_pkg;

    localparam int NODE_W        = 6;
    localparam int DATA_W        = 32;
    localparam int REST_W        = 31;
    localparam int ACC_W         = 48;
    localparam int MAX_NODES_DEF = 64;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LEN  = 2'd2;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [NODE_W-1:0]        node_a;
        logic [NODE_W-1:0]        node_b;
        logic signed [DATA_W-1:0] rel_x;
        logic signed [DATA_W-1:0] rel_y;
        logic signed [DATA_W-1:0] rel_z;
        logic signed [DATA_W-1:0] rel_vx;
        logic signed [DATA_W-1:0] rel_vy;
        logic signed [DATA_W-1:0] rel_vz;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] tension;
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic                     saturated;
    } t_out;

    // Classified item as held in the queue between front and back.
    typedef struct packed {
        logic                     is_read;
        logic                     a_ok;
        logic                     b_ok;
        logic [NODE_W-1:0]        node_a;
        logic [NODE_W-1:0]        node_b;
        logic signed [DATA_W-1:0] rel_x;
        logic signed [DATA_W-1:0] rel_y;
        logic signed [DATA_W-1:0] rel_z;
        logic signed [DATA_W-1:0] rel_vx;
        logic signed [DATA_W-1:0] rel_vy;
        logic signed [DATA_W-1:0] rel_vz;
    } t_cmd;

endpackage
`default_nettype wire

@@ design/sdefa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sdefa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/sdefa_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module sdefa_front #(
    parameter int MAX_NODES = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_hold,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  sdefa_pkg::t_in     i_in,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output sdefa_pkg::t_cmd    o_cmd
);
    import sdefa_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.is_read = (i_in.req_type == REQ_READ);
        w_cmd.a_ok    = (32'(i_in.node_a) < MAX_NODES);
        w_cmd.b_ok    = (32'(i_in.node_b) < MAX_NODES);
        w_cmd.node_a  = i_in.node_a;
        w_cmd.node_b  = i_in.node_b;
        w_cmd.rel_x   = i_in.rel_x;
        w_cmd.rel_y   = i_in.rel_y;
        w_cmd.rel_z   = i_in.rel_z;
        w_cmd.rel_vx  = i_in.rel_vx;
        w_cmd.rel_vy  = i_in.rel_vy;
        w_cmd.rel_vz  = i_in.rel_vz;
    end

    assign o_ready     = (r_cnt != 2'd2) && !i_hold;
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/sdefa_back.sv @@
// Back end: sequencer with shared multiplier, square root, divider and force store.
`default_nettype none
`include "spring_damper_edge_force_accumulator_assert.svh"
module sdefa_back #(
    parameter int MAX_NODES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  sdefa_pkg::t_cmd  i_cmd,
    input  wire logic [31:0] i_stiff,
    input  wire logic [31:0] i_damp,
    input  wire logic [30:0] i_rest,
    output logic             o_clearing,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output sdefa_pkg::t_out  o_res
);
    import sdefa_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);
    localparam int RW = 3 * ACC_W;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_RDA  = 5'd2;
    localparam logic [4:0] S_RDB  = 5'd3;
    localparam logic [4:0] S_SQ   = 5'd4;
    localparam logic [4:0] S_SQRT = 5'd5;
    localparam logic [4:0] S_CHK  = 5'd6;
    localparam logic [4:0] S_DIV  = 5'd7;
    localparam logic [4:0] S_DOT  = 5'd8;
    localparam logic [4:0] S_SPR  = 5'd9;
    localparam logic [4:0] S_DMH  = 5'd10;
    localparam logic [4:0] S_DML  = 5'd11;
    localparam logic [4:0] S_TEN  = 5'd12;
    localparam logic [4:0] S_FRC  = 5'd13;
    localparam logic [4:0] S_UA   = 5'd14;
    localparam logic [4:0] S_UA2  = 5'd15;
    localparam logic [4:0] S_UB   = 5'd16;
    localparam logic [4:0] S_UB2  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    function automatic logic [ACC_W-1:0] f_acc_add(input logic [ACC_W-1:0] a,
                                                   input logic [33:0] d);
        logic [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {{(ACC_W-33){d[33]}}, d};
            if (s[ACC_W] != s[ACC_W-1]) begin
                f_acc_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                f_acc_add = s[ACC_W-1:0];
            end
        end
    endfunction

    // {clip, value}
    function automatic logic [32:0] f_sat48(input logic signed [ACC_W-1:0] v);
        begin
            if (v > 48'sd2147483647) begin
                f_sat48 = {1'b1, 32'h7fff_ffff};
            end else if (v < -48'sd2147483648) begin
                f_sat48 = {1'b1, 32'h8000_0000};
            end else begin
                f_sat48 = {1'b0, v[31:0]};
            end
        end
    endfunction

    logic [4:0]               r_state;
    t_cmd                     r_cmd;
    logic [1:0]               r_k;
    logic [4:0]               r_step;
    logic [AW-1:0]            r_cnt;
    logic [63:0]              r_s;
    logic [33:0]              r_rem;
    logic [31:0]              r_root;
    logic [31:0]              r_drem;
    logic [16:0]              r_dq;
    logic signed [17:0]       r_u [3];
    logic signed [63:0]       r_dot;
    logic [47:0]              r_spring;
    logic [49:0]              r_dmh;
    logic signed [31:0]       r_t;
    logic signed [32:0]       r_f [3];
    t_out                     r_res;
    t_out                     r_out;
    logic                     r_ovalid;
    logic signed [65:0]       r_prod;

    logic signed [32:0]       n_ma;
    logic signed [32:0]       n_mb;
    logic [AW-1:0]            n_raddr;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [RW-1:0]            w_wdata;
    logic [RW-1:0]            w_rdata;

    logic signed [31:0]       w_rel;
    logic signed [31:0]       w_vel;
    logic [31:0]              w_rmag;
    logic signed [17:0]       w_usel;
    logic [35:0]              w_trem;
    logic [35:0]              w_trial;
    logic                     w_sq_ge;
    logic [32:0]              w_dt;
    logic                     w_dge;
    logic [32:0]              w_dnext;
    logic [16:0]              w_q;
    logic [31:0]              w_diff;
    logic [63:0]              w_dmag;
    logic [33:0]              w_m;
    logic [50:0]              w_dm;
    logic signed [52:0]       w_tot;
    logic [65:0]              w_pmag;
    logic [31:0]              w_fm;
    logic signed [32:0]       w_f;
    logic                     w_out_free;
    logic [32:0]              w_sx;
    logic [32:0]              w_sy;
    logic [32:0]              w_sz;

    always_comb begin
        case (r_k)
            2'd0: begin
                w_rel  = r_cmd.rel_x;
                w_vel  = r_cmd.rel_vx;
                w_usel = r_u[0];
            end
            2'd1: begin
                w_rel  = r_cmd.rel_y;
                w_vel  = r_cmd.rel_vy;
                w_usel = r_u[1];
            end
            2'd2: begin
                w_rel  = r_cmd.rel_z;
                w_vel  = r_cmd.rel_vz;
                w_usel = r_u[2];
            end
            default: begin
                w_rel  = '0;
                w_vel  = '0;
                w_usel = '0;
            end
        endcase
    end

    assign w_rmag  = w_rel[31] ? (32'd0 - w_rel) : w_rel;

    // One root bit per cycle, two radicand bits in.
    assign w_trem  = {r_rem, r_s[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sq_ge = (w_trem >= w_trial);

    // Restoring division, one quotient bit per cycle; quotient never exceeds 2^16.
    assign w_dt    = (r_step == 5'd0) ? {1'b0, w_rmag} : {r_drem, 1'b0};
    assign w_dge   = (w_dt >= {1'b0, r_root});
    assign w_dnext = w_dge ? (w_dt - {1'b0, r_root}) : w_dt;
    assign w_q     = (r_step == 5'd0) ? {16'd0, w_dge} : {r_dq[15:0], w_dge};

    assign w_diff  = r_root - {1'b0, i_rest};
    assign w_dmag  = r_dot[63] ? (64'd0 - r_dot) : r_dot;
    assign w_m     = w_dmag[49:16];
    assign w_dm    = {1'b0, r_dmh} + {19'd0, r_prod[47:16]};
    assign w_tot   = r_dot[63] ? ({5'd0, r_spring} - {2'd0, w_dm})
                               : ({5'd0, r_spring} + {2'd0, w_dm});

    assign w_pmag  = r_prod[65] ? (66'd0 - r_prod) : r_prod;
    assign w_fm    = w_pmag[47:16];
    assign w_f     = r_prod[65] ? (33'sd0 - {1'b0, w_fm}) : {1'b0, w_fm};

    assign w_sx    = f_sat48(w_rdata[3*ACC_W-1:2*ACC_W]);
    assign w_sy    = f_sat48(w_rdata[2*ACC_W-1:ACC_W]);
    assign w_sz    = f_sat48(w_rdata[ACC_W-1:0]);

    assign w_out_free = !r_ovalid || i_res_ready;

    // Shared multiplier operands
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (r_state)
            S_SQ: begin
                n_ma = {w_rel[31], w_rel};
                n_mb = {w_rel[31], w_rel};
            end
            S_DOT: begin
                n_ma = {w_vel[31], w_vel};
                n_mb = {{15{w_usel[17]}}, w_usel};
            end
            S_SPR: begin
                n_ma = {1'b0, i_stiff};
                n_mb = {1'b0, w_diff};
            end
            S_DMH: begin
                n_ma = {1'b0, i_damp};
                n_mb = {15'd0, w_m[33:16]};
            end
            S_DML: begin
                n_ma = {1'b0, i_damp};
                n_mb = {17'd0, w_m[15:0]};
            end
            S_FRC: begin
                n_ma = {r_t[31], r_t};
                n_mb = {{15{w_usel[17]}}, w_usel};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    // Store access
    always_comb begin
        n_raddr = AW'(r_cmd.node_a);
        w_we    = 1'b0;
        w_waddr = AW'(r_cmd.node_a);
        w_wdata = '0;
        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
            end
            S_RDB: begin
                w_we = 1'b1;
            end
            S_UB: begin
                n_raddr = AW'(r_cmd.node_b);
            end
            S_UA2: begin
                w_we    = 1'b1;
                w_wdata = {f_acc_add(w_rdata[3*ACC_W-1:2*ACC_W], {r_f[0][32], r_f[0]}),
                           f_acc_add(w_rdata[2*ACC_W-1:ACC_W], {r_f[1][32], r_f[1]}),
                           f_acc_add(w_rdata[ACC_W-1:0], {r_f[2][32], r_f[2]})};
            end
            S_UB2: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_cmd.node_b);
                w_wdata = {f_acc_add(w_rdata[3*ACC_W-1:2*ACC_W],
                                     34'sd0 - {r_f[0][32], r_f[0]}),
                           f_acc_add(w_rdata[2*ACC_W-1:ACC_W],
                                     34'sd0 - {r_f[1][32], r_f[1]}),
                           f_acc_add(w_rdata[ACC_W-1:0],
                                     34'sd0 - {r_f[2][32], r_f[2]})};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    sdefa_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_NODES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(n_raddr),
        .o_rdata(w_rdata)
    );

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_clearing  = (r_state == S_CLR);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_res <= '0;
                    r_s   <= '0;
                end
            end
            S_RDB: begin
                r_res.force_x   <= w_sx[31:0];
                r_res.force_y   <= w_sy[31:0];
                r_res.force_z   <= w_sz[31:0];
                r_res.saturated <= w_sx[32] | w_sy[32] | w_sz[32];
            end
            S_SQ: begin
                if (r_k != 2'd0) begin
                    r_s <= r_s + r_prod[63:0];
                end
                r_rem  <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_s    <= {r_s[61:0], 2'b00};
                r_rem  <= w_sq_ge ? 34'(w_trem - w_trial) : w_trem[33:0];
                r_root <= {r_root[30:0], w_sq_ge};
            end
            S_DIV: begin
                r_drem <= w_dnext[31:0];
                r_dq   <= w_q;
                if (r_step == 5'd16) begin
                    r_u[r_k] <= w_rel[31] ? (18'sd0 - {1'b0, w_q}) : {1'b0, w_q};
                end
                r_dot <= '0;
            end
            S_DOT: begin
                if (r_k != 2'd0) begin
                    r_dot <= r_dot + r_prod[63:0];
                end
            end
            S_DMH: begin
                r_spring <= r_prod[63:16];
            end
            S_DML: begin
                r_dmh <= r_prod[49:0];
            end
            S_TEN: begin
                if (w_tot > 53'sd2147483647) begin
                    r_t             <= 32'sh7fff_ffff;
                    r_res.saturated <= 1'b1;
                end else if (w_tot < -53'sd2147483648) begin
                    r_t             <= 32'sh8000_0000;
                    r_res.saturated <= 1'b1;
                end else begin
                    r_t             <= w_tot[31:0];
                    r_res.saturated <= 1'b0;
                end
            end
            S_FRC: begin
                r_res.tension <= r_t;
                if (r_k != 2'd0) begin
                    r_f[r_k - 2'd1] <= w_f;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_k      <= 2'd0;
            r_step   <= 5'd0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_res_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_k    <= 2'd0;
                    r_step <= 5'd0;
                    if (i_cmd_valid) begin
                        if (i_cmd.is_read) begin
                            r_state <= i_cmd.a_ok ? S_RDA : S_OUT;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_state <= S_OUT;
                end
                S_SQ: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_step  <= 5'd0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_k    <= 2'd0;
                    r_step <= 5'd0;
                    r_state <= (r_root > {1'b0, i_rest}) ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (r_step == 5'd16) begin
                        r_step <= 5'd0;
                        r_k    <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            r_state <= S_DOT;
                        end
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                S_DOT: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_SPR;
                    end
                end
                S_SPR: begin
                    r_state <= S_DMH;
                end
                S_DMH: begin
                    r_state <= S_DML;
                end
                S_DML: begin
                    r_state <= S_TEN;
                end
                S_TEN: begin
                    r_k     <= 2'd0;
                    r_state <= S_FRC;
                end
                S_FRC: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_UA;
                    end
                end
                S_UA: begin
                    r_state <= r_cmd.a_ok ? S_UA2 : S_UB;
                end
                S_UA2: begin
                    r_state <= S_UB;
                end
                S_UB: begin
                    r_state <= r_cmd.b_ok ? S_UB2 : S_OUT;
                end
                S_UB2: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out <= r_res;
        end
    end

    `SDEFA_ASSERT_SAME(a_clr_no_pop, i_clk, i_rst_n, r_state == S_CLR, !o_cmd_ready, "item taken during clearing pass")
    `SDEFA_ASSERT_SAME(a_we_states, i_clk, i_rst_n, w_we, (r_state == S_CLR) || (r_state == S_RDB) || (r_state == S_UA2) || (r_state == S_UB2), "store written outside a write step")
    `SDEFA_ASSERT_SAME(a_unit_range, i_clk, i_rst_n, r_state == S_SPR, (r_u[0] <= 18'sd65536) && (r_u[0] >= -18'sd65536), "unit vector component out of range")
    `SDEFA_ASSERT_NEXT(a_out_wait, i_clk, i_rst_n, (r_state == S_OUT) && r_ovalid && !i_res_ready, r_state == S_OUT, "result dropped while output busy")

endmodule
`default_nettype wire

@@ design/spring_damper_edge_force_accumulator.sv @@
// Top level of the tension-only spring-damper edge force accumulator.
//
// Takes one item at a time: an edge (two node indices, relative position and
// velocity in Q16.16) or a read-and-clear of one node's force. An edge
// computes length by a bit-serial square root, the unit vector with a
// restoring divider one axis after another, then tension and per-axis
// forces on one shared 33x33 multiplier, and updates both endpoints in a
// 144-bit wide force store by read-modify-write. A slack edge ends in the
// back end after the length check, and a read of a node outside the store
// skips the store; any item may also wait for the output register to free.
// The front end holds a two-deep item queue, so up to two items are taken
// while the back end works, and a finished result waits in an output
// register without blocking the queue. After reset the force store is
// cleared one entry per cycle; no item is accepted during that pass, while
// configuration writes are taken at any time.
`default_nettype none
module spring_damper_edge_force_accumulator #(
    parameter int MAX_NODES = sdefa_pkg::MAX_NODES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  sdefa_pkg::t_in                        i_in,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output sdefa_pkg::t_out                       o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [sdefa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sdefa_pkg::DATA_W-1:0]     i_cfg_data
);
    import sdefa_pkg::*;

    // configuration registers
    logic [DATA_W-1:0] r_stiff;
    logic [DATA_W-1:0] r_damp;
    logic [REST_W-1:0] r_rest;

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;
    logic w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= '0;
            r_damp  <= '0;
            r_rest  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STIFFNESS: begin
                    r_stiff <= i_cfg_data;
                end
                REG_DAMPING: begin
                    r_damp <= i_cfg_data;
                end
                REG_REST_LEN: begin
                    r_rest <= i_cfg_data[REST_W-1:0];
                end
                default: begin
                    r_rest <= r_rest;  // unmapped index: ignored
                end
            endcase
        end
    end

    // front: accept and classify, two-deep queue
    sdefa_front #(
        .MAX_NODES(MAX_NODES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (w_clearing),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_ready(w_cmd_ready),
        .o_cmd      (w_cmd)
    );

    // back: arithmetic sequencer and force store
    sdefa_back #(
        .MAX_NODES(MAX_NODES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_ready(w_cmd_ready),
        .i_cmd      (w_cmd),
        .i_stiff    (r_stiff),
        .i_damp     (r_damp),
        .i_rest     (r_rest),
        .o_clearing (w_clearing),
        .o_res_valid(o_valid),
        .i_res_ready(i_ready),
        .o_res      (o_res)
    );
endmodule
`default_nettype wire
